// ===== rtl/dde_pkg.sv =====
// Shared constants, widths and types of the dust density estimator.
package dde_pkg;

  localparam int READING_SAMPLES  = 10;
  localparam int BASELINE_SAMPLES = 50;
  localparam int ADC_BITS         = 12;

  localparam int MAX_SAMPLES = (READING_SAMPLES > BASELINE_SAMPLES) ?
                               READING_SAMPLES : BASELINE_SAMPLES;

  // field and register widths
  localparam int WARM_W   = 16;
  localparam int GAIN_W   = 18;
  localparam int LIM_W    = 10;
  localparam int LVL_W    = 3;
  localparam int NBOUNDS  = 5;
  localparam int CNT_W    = 16;
  localparam int FRAC_W   = 8;
  localparam int AVG_W    = ADC_BITS + FRAC_W;
  localparam int SUM_W    = $clog2(MAX_SAMPLES * ((2 ** ADC_BITS) - 1) + 1);
  localparam int NUM_W    = SUM_W + FRAC_W;
  localparam int DENS_W   = AVG_W + GAIN_W;
  localparam int QFRAC_W  = 24;
  localparam int CLAMP_W  = LIM_W + QFRAC_W;
  localparam int NDIV_W   = $clog2(MAX_SAMPLES + 1);

  // APB register map
  localparam int DATA_W   = 32;
  localparam int NREGS    = 8;
  localparam int REGIDX_W = $clog2(NREGS);
  localparam int ADDR_W   = REGIDX_W + 2;

  // reciprocal divide by a constant count: q ~ (num * M) >> DIV_SH
  localparam int DIV_SH = NUM_W;
  localparam logic [DIV_SH:0] RECIP_BASE =
    (DIV_SH+1)'((64'd1 << DIV_SH) / BASELINE_SAMPLES);
  localparam logic [DIV_SH:0] RECIP_READ =
    (DIV_SH+1)'((64'd1 << DIV_SH) / READING_SAMPLES);
  localparam logic [NDIV_W-1:0] NDIV_BASE = NDIV_W'(BASELINE_SAMPLES);
  localparam logic [NDIV_W-1:0] NDIV_READ = NDIV_W'(READING_SAMPLES);

  typedef enum logic [REGIDX_W-1:0] {
    REG_WARMUP  = 3'd0,
    REG_GAIN    = 3'd1,
    REG_LIMIT   = 3'd2,
    REG_BOUND1  = 3'd3,
    REG_BOUND2  = 3'd4,
    REG_BOUND3  = 3'd5,
    REG_BOUND4  = 3'd6,
    REG_BOUND5  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [WARM_W-1:0]              warmup;
    logic [GAIN_W-1:0]              gain;
    logic [LIM_W-1:0]               limit;
    logic [NBOUNDS-1:0][LIM_W-1:0]  bound;
  } cfg_t;

  // group-average request from the accumulator to the divider
  typedef struct packed {
    logic             calib;
    logic [SUM_W-1:0] sum;
  } div_req_t;

  // divider result
  typedef struct packed {
    logic             calib;
    logic [AVG_W-1:0] avg;
  } div_res_t;

endpackage

// ===== rtl/dust_density_estimator.sv =====
// Top level of the dust density estimator.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-------------------------------------------
//   in      | input     | in_valid/ready   | in_adc_sample
//   out     | output    | out_valid/ready  | out_dust_density, out_air_level,
//           |           |                  | out_baseline_level, out_group_average
//   cfg     | input     | APB psel/penable | paddr, pwdata, prdata (pready tied high)
//
// One sample is taken per cycle while in_ready is high. A group-ending sample's
// result passes through the divider's A, B and C registers, then the gain multiply
// and classify registers. Reset is synchronous, active low, and restores the register
// defaults and warmup. A stalled output backs up the pipeline stage by stage; once every
// stage is full, in_ready drops for every item, whether it ends a group or not.
module dust_density_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dde_pkg::ADC_BITS-1:0]  in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dde_pkg::LIM_W-1:0]     out_dust_density,
  output logic [dde_pkg::LVL_W-1:0]     out_air_level,
  output logic [dde_pkg::AVG_W-1:0]     out_baseline_level,
  output logic [dde_pkg::AVG_W-1:0]     out_group_average,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dde_pkg::ADDR_W-1:0]    paddr,
  input  logic [dde_pkg::DATA_W-1:0]    pwdata,
  output logic [dde_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import dde_pkg::*;

  cfg_t      cfg;
  div_req_t  req;
  div_res_t  res;
  logic      req_valid, req_ready;
  logic      res_valid, res_ready;
  logic      grp_end;

  dde_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dde_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .warmup        (cfg.warmup),
    .req_valid     (grp_end),
    .req           (req)
  );

  // every item waits for room in the divider; only a group-ending one enters it
  assign req_valid = grp_end;
  assign in_ready  = req_ready;

  dde_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dde_density u_density (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res                (res),
    .cfg                (cfg),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dust_density   (out_dust_density),
    .out_air_level      (out_air_level),
    .out_baseline_level (out_baseline_level),
    .out_group_average  (out_group_average)
  );

endmodule

// ===== rtl/dde_cfg.sv =====
// APB configuration registers of the dust density estimator.
module dde_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dde_pkg::ADDR_W-1:0]  paddr,
  input  logic [dde_pkg::DATA_W-1:0]  pwdata,
  output logic [dde_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dde_pkg::cfg_t               cfg
);
  import dde_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [REGIDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(idx))
        REG_WARMUP: cfg_nxt.warmup   = pwdata[WARM_W-1:0];
        REG_GAIN:   cfg_nxt.gain     = pwdata[GAIN_W-1:0];
        REG_LIMIT:  cfg_nxt.limit    = pwdata[LIM_W-1:0];
        REG_BOUND1: cfg_nxt.bound[0] = pwdata[LIM_W-1:0];
        REG_BOUND2: cfg_nxt.bound[1] = pwdata[LIM_W-1:0];
        REG_BOUND3: cfg_nxt.bound[2] = pwdata[LIM_W-1:0];
        REG_BOUND4: cfg_nxt.bound[3] = pwdata[LIM_W-1:0];
        REG_BOUND5: cfg_nxt.bound[4] = pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(idx))
      REG_WARMUP: prdata = DATA_W'(cfg_r.warmup);
      REG_GAIN:   prdata = DATA_W'(cfg_r.gain);
      REG_LIMIT:  prdata = DATA_W'(cfg_r.limit);
      REG_BOUND1: prdata = DATA_W'(cfg_r.bound[0]);
      REG_BOUND2: prdata = DATA_W'(cfg_r.bound[1]);
      REG_BOUND3: prdata = DATA_W'(cfg_r.bound[2]);
      REG_BOUND4: prdata = DATA_W'(cfg_r.bound[3]);
      REG_BOUND5: prdata = DATA_W'(cfg_r.bound[4]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup   <= WARM_W'(484);
      cfg_r.gain     <= GAIN_W'(52813);
      cfg_r.limit    <= LIM_W'(600);
      cfg_r.bound[0] <= LIM_W'(12);
      cfg_r.bound[1] <= LIM_W'(35);
      cfg_r.bound[2] <= LIM_W'(55);
      cfg_r.bound[3] <= LIM_W'(150);
      cfg_r.bound[4] <= LIM_W'(250);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/dde_accum.sv =====
// Phase sequencing and sample accumulation; issues one request per finished group.
module dde_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [dde_pkg::ADC_BITS-1:0]  in_adc_sample,
  input  logic [dde_pkg::WARM_W-1:0]    warmup,
  output logic                          req_valid,
  output dde_pkg::div_req_t             req
);
  import dde_pkg::*;

  typedef enum logic [2:0] {
    PH_WARMUP  = 3'b001,
    PH_CALIB   = 3'b010,
    PH_MEASURE = 3'b100
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic              issue;
  logic              issue_calib;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign sum_add = sum_r + SUM_W'(in_adc_sample);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    issue       = 1'b0;
    issue_calib = 1'b0;
    req.sum     = sum_add;
    case (phase_r)
      PH_CALIB: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(BASELINE_SAMPLES)) begin
          issue       = 1'b1;
          issue_calib = 1'b1;
          phase_nxt   = PH_MEASURE;
          cnt_nxt     = '0;
          sum_nxt     = '0;
        end
      end
      PH_MEASURE: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(READING_SAMPLES)) begin
          issue   = 1'b1;
          cnt_nxt = '0;
          sum_nxt = '0;
        end
      end
      default: begin
        // warmup and any stray code
        phase_nxt = PH_WARMUP;
        if (cnt_r < warmup) begin
          cnt_nxt = cnt_inc;
        end else begin
          // this sample is already the first one of calibration
          req.sum   = SUM_W'(in_adc_sample);
          sum_nxt   = SUM_W'(in_adc_sample);
          cnt_nxt   = CNT_W'(1);
          phase_nxt = PH_CALIB;
          if (BASELINE_SAMPLES <= 1) begin
            issue       = 1'b1;
            issue_calib = 1'b1;
            phase_nxt   = PH_MEASURE;
            cnt_nxt     = '0;
            sum_nxt     = '0;
          end
        end
      end
    endcase
    req.calib = issue_calib;
  end

  assign req_valid = in_valid && issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WARMUP;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== rtl/dde_div.sv =====
// Pipelined divide of a group sum by its constant sample count, giving a 12.8 average.
module dde_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  dde_pkg::div_req_t  req,
  output logic               res_valid,
  input  logic               res_ready,
  output dde_pkg::div_res_t  res
);
  import dde_pkg::*;

  logic                      a_v_r, b_v_r, c_v_r;
  logic                      a_cal_r, b_cal_r;
  logic [NUM_W-1:0]          a_num_r, b_num_r;
  logic [NUM_W+DIV_SH:0]     b_prod_r, prod_nxt;
  div_res_t                  c_r, c_nxt;
  logic [DIV_SH:0]           recip;
  logic [NDIV_W-1:0]         ndiv;
  logic [NUM_W-1:0]          q_est, rem;
  logic                      a_rdy, b_rdy, c_rdy;

  assign c_rdy     = !c_v_r || res_ready;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign req_ready = a_rdy;

  // stage A -> B: multiply by the reciprocal, low by at most one
  assign recip    = a_cal_r ? RECIP_BASE : RECIP_READ;
  assign prod_nxt = a_num_r * recip;

  // stage B -> C: one correction step
  assign ndiv  = b_cal_r ? NDIV_BASE : NDIV_READ;
  assign q_est = b_prod_r[NUM_W+DIV_SH-1:DIV_SH];
  assign rem   = b_num_r - NUM_W'(q_est * ndiv);

  always_comb begin
    c_nxt.calib = b_cal_r;
    if (rem >= NUM_W'(ndiv)) begin
      c_nxt.avg = AVG_W'(q_est + NUM_W'(1));
    end else begin
      c_nxt.avg = AVG_W'(q_est);
    end
  end

  assign res_valid = c_v_r;
  assign res       = c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= req_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && req_valid) begin
      a_num_r <= {req.sum, {FRAC_W{1'b0}}};
      a_cal_r <= req.calib;
    end
    if (b_rdy && a_v_r) begin
      b_prod_r <= prod_nxt;
      b_num_r  <= a_num_r;
      b_cal_r  <= a_cal_r;
    end
    if (c_rdy && b_v_r) begin
      c_r <= c_nxt;
    end
  end

endmodule

// ===== rtl/dde_density.sv =====
// Baseline store, gain multiply, saturation, level classification and result register.
module dde_density (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  dde_pkg::div_res_t             res,
  input  dde_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dde_pkg::LIM_W-1:0]     out_dust_density,
  output logic [dde_pkg::LVL_W-1:0]     out_air_level,
  output logic [dde_pkg::AVG_W-1:0]     out_baseline_level,
  output logic [dde_pkg::AVG_W-1:0]     out_group_average
);
  import dde_pkg::*;

  logic [AVG_W-1:0]    base_r;
  logic                d_v_r, o_v_r;
  logic [DENS_W-1:0]   d_dens_r;
  logic [AVG_W-1:0]    d_avg_r, o_avg_r;
  logic [LIM_W-1:0]    o_dens_r;
  logic [LVL_W-1:0]    o_lvl_r, lvl_nxt;
  logic [AVG_W-1:0]    delta;
  logic [CLAMP_W-1:0]  cap, dens_c;
  logic [NBOUNDS-1:0]  above;
  logic                d_rdy, o_rdy;

  assign o_rdy     = !o_v_r || out_ready;
  assign d_rdy     = !d_v_r || o_rdy;
  // a calibration result only loads the baseline
  assign res_ready = res.calib || d_rdy;

  assign delta = (res.avg > base_r) ? (res.avg - base_r) : '0;
  assign cap   = {cfg.limit, {QFRAC_W{1'b0}}};

  always_comb begin
    if (d_dens_r > DENS_W'(cap)) begin
      dens_c = cap;
    end else begin
      dens_c = CLAMP_W'(d_dens_r);
    end
    for (int k = 0; k < NBOUNDS; k++) begin
      above[k] = dens_c > {cfg.bound[k], {QFRAC_W{1'b0}}};
    end
    // first bound not exceeded sets the level
    lvl_nxt = LVL_W'(NBOUNDS);
    for (int k = NBOUNDS - 1; k >= 0; k--) begin
      if (!above[k]) lvl_nxt = LVL_W'(k);
    end
  end

  assign out_valid          = o_v_r;
  assign out_dust_density   = o_dens_r;
  assign out_air_level      = o_lvl_r;
  assign out_baseline_level = base_r;
  assign out_group_average  = o_avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
      base_r <= '0;
    end else begin
      if (res_valid && res.calib) base_r <= res.avg;
      if (d_rdy) d_v_r <= res_valid && !res.calib;
      if (o_rdy) o_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && res_valid && !res.calib) begin
      d_dens_r <= delta * cfg.gain;
      d_avg_r  <= res.avg;
    end
    if (o_rdy && d_v_r) begin
      o_dens_r <= dens_c[CLAMP_W-1:QFRAC_W];
      o_lvl_r  <= lvl_nxt;
      o_avg_r  <= d_avg_r;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the dust density estimator.
`timescale 1ns / 1ps

module tb_top;
  import dde_pkg::*;

  localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {WARMING, CALIBRATING, MEASURING} est_phase_t;

  typedef struct packed {
    logic [LIM_W-1:0] density_ug;
    logic [LVL_W-1:0] air_level;
    logic [AVG_W-1:0] baseline_level;
    logic [AVG_W-1:0] group_average;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ADC_BITS-1:0] in_adc_sample;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LIM_W-1:0]    out_dust_density;
  logic [LVL_W-1:0]    out_air_level;
  logic [AVG_W-1:0]    out_baseline_level;
  logic [AVG_W-1:0]    out_group_average;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state and register copy
  cfg_t             density_cfg;
  est_phase_t       est_phase;
  logic [CNT_W-1:0] est_count;
  logic [SUM_W-1:0] est_sum;
  logic [AVG_W-1:0] est_baseline;
  reading_t         pending_readings[$];

  int       mismatch_count = 0;
  int       burst_left = 0;
  int       gap_max = 0;
  logic [7:0] ready_pattern = 8'hFF;
  logic [2:0] stall_idx = '0;

  dust_density_estimator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dust_density   (out_dust_density),
    .out_air_level      (out_air_level),
    .out_baseline_level (out_baseline_level),
    .out_group_average  (out_group_average),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 40)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [AVG_W-1:0] q8_average(input logic [SUM_W-1:0] sum, input int n);
    return AVG_W'((64'(sum) << FRAC_W) / n);
  endfunction

  // Advance the predictor by one accepted sample; queue a reading when a group closes.
  function automatic void estimate_density(input logic [ADC_BITS-1:0] value);
    logic [AVG_W-1:0] avg;
    logic [AVG_W-1:0] delta;
    logic [63:0]      dens;
    logic [63:0]      cap;
    int               lvl;
    bit               passing;
    reading_t         r;
    if (est_phase != CALIBRATING && est_phase != MEASURING) begin
      est_phase = WARMING;
      if (est_count < density_cfg.warmup) begin
        est_count++;
        return;
      end
      est_phase = CALIBRATING;
      est_count = '0;
      est_sum   = '0;
    end
    est_sum += value;
    est_count++;
    if (est_phase == CALIBRATING) begin
      if (est_count >= BASELINE_SAMPLES) begin
        est_baseline = q8_average(est_sum, BASELINE_SAMPLES);
        est_phase    = MEASURING;
        est_count    = '0;
        est_sum      = '0;
      end
      return;
    end
    if (est_count < READING_SAMPLES) return;
    avg   = q8_average(est_sum, READING_SAMPLES);
    delta = (avg > est_baseline) ? avg - est_baseline : '0;
    dens  = 64'(delta) * 64'(density_cfg.gain);
    cap   = 64'(density_cfg.limit) << QFRAC_W;
    if (dens > cap) dens = cap;
    // first bound not exceeded sets the level, even when bounds are unordered
    lvl     = 0;
    passing = 1'b1;
    for (int k = 0; k < NBOUNDS; k++) begin
      if (passing && dens > (64'(density_cfg.bound[k]) << QFRAC_W)) lvl++;
      else passing = 1'b0;
    end
    r.density_ug     = LIM_W'(dens >> QFRAC_W);
    r.air_level      = LVL_W'(lvl);
    r.baseline_level = est_baseline;
    r.group_average  = avg;
    pending_readings.push_back(r);
    est_count = '0;
    est_sum   = '0;
  endfunction

  function automatic logic [DATA_W-1:0] shadow_value(input reg_idx_t idx);
    case (idx)
      REG_WARMUP: return DATA_W'(density_cfg.warmup);
      REG_GAIN:   return DATA_W'(density_cfg.gain);
      REG_LIMIT:  return DATA_W'(density_cfg.limit);
      default:    return DATA_W'(density_cfg.bound[int'(idx) - int'(REG_BOUND1)]);
    endcase
  endfunction

  function automatic int reg_width(input reg_idx_t idx);
    case (idx)
      REG_WARMUP: return WARM_W;
      REG_GAIN:   return GAIN_W;
      default:    return LIM_W;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ready_pattern[stall_idx];
    stall_idx <= stall_idx + 1'b1;
  end

  always @(posedge clk)
    if (rst_n && in_valid && in_ready) estimate_density(in_adc_sample);

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with nothing pending", out_dust_density, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_dust_density !== want.density_ug)
          report_mismatch("density", out_dust_density, want.density_ug);
        if (out_air_level !== want.air_level)
          report_mismatch("air_level", out_air_level, want.air_level);
        if (out_baseline_level !== want.baseline_level)
          report_mismatch("baseline_level", out_baseline_level, want.baseline_level);
        if (out_group_average !== want.group_average)
          report_mismatch("group_average", out_group_average, want.group_average);
      end
    end
  end

  task automatic check_register(input reg_idx_t idx);
    logic [DATA_W-1:0] mask;
    mask    = (DATA_W'(1) << reg_width(idx)) - 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== shadow_value(idx))
      report_mismatch($sformatf("register %s readback", idx.name()),
                      prdata & mask, shadow_value(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WARMUP: density_cfg.warmup = value[WARM_W-1:0];
      REG_GAIN:   density_cfg.gain   = value[GAIN_W-1:0];
      REG_LIMIT:  density_cfg.limit  = value[LIM_W-1:0];
      default:    density_cfg.bound[int'(idx) - int'(REG_BOUND1)] = value[LIM_W-1:0];
    endcase
    check_register(idx);
  endtask

  // Sender: bursts of random length, random gaps between bursts.
  task automatic send_sample(input int value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_adc_sample <= value[ADC_BITS-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_group(input int center, input int spread);
    int s;
    repeat (READING_SAMPLES) begin
      s = center + int'($urandom_range(0, 2 * spread)) - spread;
      send_sample(s < 0 ? 0 : (s > ADC_MAX ? ADC_MAX : s));
    end
  endtask

  // Stop sending, let every pending reading drain, then cover the pipeline depth.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    // let the predictor take in the last accepted item
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int clean_air_code();
    return int'(est_baseline >> FRAC_W);
  endfunction

  task automatic test_register_defaults();
    for (int i = 0; i < NREGS; i++) check_register(reg_idx_t'(i));
  endtask

  task automatic test_warmup_change();
    write_register(REG_WARMUP, 65535);
    repeat (3) send_sample($urandom_range(0, ADC_MAX));
    wait_idle();
    // count already equals the new value: the next item starts calibration
    write_register(REG_WARMUP, 3);
  endtask

  task automatic test_calibration();
    send_sample(0);
    send_sample(ADC_MAX);
    repeat (BASELINE_SAMPLES - 2) send_sample($urandom_range(300, 700));
  endtask

  task automatic test_density_extremes();
    send_group(0, 0);                   // below baseline, floored
    send_group(ADC_MAX, 0);             // saturated, hazardous
    send_group(clean_air_code() + 40, 6);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    int unordered[NBOUNDS] = '{500, 100, 900, 0, 1023};
    // clamp lands exactly on a bound: not above it
    write_register(REG_LIMIT, 35);
    send_group(ADC_MAX, 0);
    wait_idle();
    write_register(REG_LIMIT, 12);
    send_group(ADC_MAX, 0);
    wait_idle();
    write_register(REG_LIMIT, 0);
    send_group(ADC_MAX, 0);
    wait_idle();
    write_register(REG_GAIN, 0);
    write_register(REG_LIMIT, 1023);
    send_group(ADC_MAX, 0);
    wait_idle();
    write_register(REG_GAIN, 262143);
    for (int k = 0; k < NBOUNDS; k++) write_register(reg_idx_t'(int'(REG_BOUND1) + k), 0);
    send_group(ADC_MAX, 0);
    send_group(clean_air_code() + 1, 0);
    wait_idle();
    write_register(REG_WARMUP, 0);      // no effect once measuring
    write_register(REG_GAIN, 52813);
    for (int k = 0; k < NBOUNDS; k++)
      write_register(reg_idx_t'(int'(REG_BOUND1) + k), unordered[k]);
    send_group(clean_air_code() + 300, 20);
    send_group(clean_air_code() + 1000, 20);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int gain;
    int limit;
    int bound;
    bit ordered;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143)
                                         : $urandom_range(20000, 120000);
      write_register(REG_GAIN, gain);
      limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(200, 1023);
      write_register(REG_LIMIT, limit);
      ordered = ($urandom_range(0, 3) != 0);
      bound   = 0;
      for (int k = 0; k < NBOUNDS; k++) begin
        bound = ordered ? bound + int'($urandom_range(0, 250)) : $urandom_range(0, 1023);
        if (bound > 1023) bound = 1023;
        write_register(reg_idx_t'(int'(REG_BOUND1) + k), bound);
      end
      if ($urandom_range(0, 1)) write_register(REG_WARMUP, $urandom_range(0, 65535));
      // first phase runs with no idling on either side
      gap_max       = (p == 0) ? 0 : $urandom_range(0, 8);
      ready_pattern = (p == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      repeat (8) begin
        case ($urandom_range(0, 9))
          0:       send_group(2048, 2048);
          1:       send_group(clean_air_code() - int'($urandom_range(0, 300)), 16);
          default: send_group(clean_air_code() + int'($urandom_range(0, 1400)),
                              $urandom_range(0, 40));
        endcase
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_adc_sample <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    density_cfg.warmup   = 16'd484;
    density_cfg.gain     = 18'd52813;
    density_cfg.limit    = 10'd600;
    density_cfg.bound[0] = 10'd12;
    density_cfg.bound[1] = 10'd35;
    density_cfg.bound[2] = 10'd55;
    density_cfg.bound[3] = 10'd150;
    density_cfg.bound[4] = 10'd250;
    est_phase    = WARMING;
    est_count    = '0;
    est_sum      = '0;
    est_baseline = '0;
    gap_max       = 3;
    ready_pattern = 8'b1011_0110;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_warmup_change();
    test_calibration();
    test_density_extremes();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
